/* design/mch_pkg.sv */
package mch_pkg;

   localparam int CordicStepsDefault = 16;
   localparam int TableLen           = 24;
   localparam int AngW               = 26;   // Q.16 degrees, +-270 deg fits
   localparam int CrdW               = 27;   // CORDIC x/y working width

   typedef enum logic [2:0] {
      CSR_AXIS_SCALE = 3'd0,
      CSR_AXIS_BIAS  = 3'd1,
      CSR_IRON_ROW_X = 3'd2,
      CSR_IRON_ROW_Y = 3'd3,
      CSR_IRON_ROW_Z = 3'd4,
      CSR_DECL       = 3'd5
   } csr_index_type;

   // one CORDIC cell's travelling context
   typedef struct packed {
      logic                   vld;
      logic signed [CrdW-1:0] x;
      logic signed [CrdW-1:0] y;
      logic signed [AngW-1:0] ang;
      logic                   zero;
      logic                   neg;
      logic signed [23:0]     cx;
      logic signed [23:0]     cy;
      logic signed [23:0]     cz;
   } cell_type;

   // rounded arctangent in Q.16 degrees
   function automatic logic signed [AngW-1:0] atan_q16(input int i);
      logic signed [AngW-1:0] v;
      case (i)
         0: v = 26'sd2949120;  1: v = 26'sd1740967;  2: v = 26'sd919879;
         3: v = 26'sd466945;   4: v = 26'sd234379;   5: v = 26'sd117304;
         6: v = 26'sd58666;    7: v = 26'sd29335;    8: v = 26'sd14668;
         9: v = 26'sd7334;    10: v = 26'sd3667;    11: v = 26'sd1833;
        12: v = 26'sd917;     13: v = 26'sd458;     14: v = 26'sd229;
        15: v = 26'sd115;     16: v = 26'sd57;      17: v = 26'sd29;
        18: v = 26'sd14;      19: v = 26'sd7;       20: v = 26'sd4;
        21: v = 26'sd2;       22: v = 26'sd1;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

/* design/mch_cordic_cell.sv */
module mch_cordic_cell import mch_pkg::*; #(
   parameter int STEP = 0
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     advance,
   input  cell_type cell_in,
   output cell_type cell_out
);

   cell_type               cell_ff;
   cell_type               cell_in_w;
   logic signed [CrdW-1:0] dx;
   logic signed [CrdW-1:0] dy;

   // arithmetic shift is a floor shift
   always_comb begin
      dx        = cell_in.y >>> STEP;
      dy        = cell_in.x >>> STEP;
      cell_in_w = cell_in;
      if (cell_in.y > 0) begin
         cell_in_w.x   = cell_in.x + dx;
         cell_in_w.y   = cell_in.y - dy;
         cell_in_w.ang = cell_in.ang + atan_q16(STEP);
      end else begin
         cell_in_w.x   = cell_in.x - dx;
         cell_in_w.y   = cell_in.y + dy;
         cell_in_w.ang = cell_in.ang - atan_q16(STEP);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.vld <= 1'b0;
      end else if (advance) begin
         cell_ff <= cell_in_w;
      end
   end

   assign cell_out = cell_ff;

endmodule

/* design/mch_front.sv */
module mch_front import mch_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               in_vld,
   input  logic signed [15:0] raw_x,
   input  logic signed [15:0] raw_y,
   input  logic signed [15:0] raw_z,
   input  logic [47:0]        axis_scale,
   input  logic [59:0]        axis_bias,
   input  logic [47:0]        iron_row_x,
   input  logic [47:0]        iron_row_y,
   input  logic [47:0]        iron_row_z,
   output cell_type           cell_out
);

   // stage 1: gain and bias
   logic               s1_vld_ff;
   logic signed [25:0] off_ff [3];
   logic               neg1_ff;
   // stage 2: products
   logic               s2_vld_ff;
   logic signed [41:0] prod_ff [9];
   logic               neg2_ff;
   // stage 3: calibrated axes and CORDIC pre-rotation
   cell_type           cell_ff;

   logic signed [25:0] off_in [3];
   logic signed [15:0] raws   [3];
   logic signed [15:0] coef   [9];
   logic signed [43:0] sum    [3];
   logic signed [23:0] sat    [3];
   cell_type           cell_in;

   assign raws[0] = raw_x;
   assign raws[1] = raw_y;
   assign raws[2] = raw_z;

   always_comb begin
      logic signed [33:0] p;
      for (int k = 0; k < 3; k++) begin
         p = raws[k] * $signed({1'b0, axis_scale[16*k +: 16]}) + 34'sd64;
         off_in[k] = 26'(p >>> 7) - 26'($signed(axis_bias[20*k +: 20]));
      end
      for (int k = 0; k < 3; k++) begin
         coef[k]     = iron_row_x[16*k +: 16];
         coef[3 + k] = iron_row_y[16*k +: 16];
         coef[6 + k] = iron_row_z[16*k +: 16];
      end
   end

   // round, floor shift, saturate
   always_comb begin
      logic signed [43:0] r;
      for (int j = 0; j < 3; j++) begin
         sum[j] = 44'(prod_ff[3*j]) + 44'(prod_ff[3*j+1]) + 44'(prod_ff[3*j+2]);
         r      = (sum[j] + 44'sd8192) >>> 14;
         if (r > 44'sd8388607)       sat[j] = 24'sh7FFFFF;
         else if (r < -44'sd8388608) sat[j] = 24'sh800000;
         else                        sat[j] = r[23:0];
      end
   end

   // move left half plane points into the right half
   always_comb begin
      cell_in      = '0;
      cell_in.vld  = s2_vld_ff;
      cell_in.neg  = neg2_ff;
      cell_in.cx   = sat[0];
      cell_in.cy   = sat[1];
      cell_in.cz   = sat[2];
      cell_in.zero = (sat[0] == '0) && (sat[1] == '0);
      cell_in.x    = CrdW'(sat[0]);
      cell_in.y    = CrdW'(sat[1]);
      if (sat[0] < 0) begin
         if (sat[1] >= 0) begin
            cell_in.x   = CrdW'(sat[1]);
            cell_in.y   = -CrdW'(sat[0]);
            cell_in.ang = AngW'(90 <<< 16);
         end else begin
            cell_in.x   = -CrdW'(sat[1]);
            cell_in.y   = CrdW'(sat[0]);
            cell_in.ang = -AngW'(90 <<< 16);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff   <= 1'b0;
         s2_vld_ff   <= 1'b0;
         cell_ff.vld <= 1'b0;
      end else if (advance) begin
         s1_vld_ff <= in_vld;
         neg1_ff   <= raw_z > 0;
         off_ff    <= off_in;
         s2_vld_ff <= s1_vld_ff;
         neg2_ff   <= neg1_ff;
         for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < 3; k++) begin
               prod_ff[3*j+k] <= coef[3*j+k] * off_ff[k];
            end
         end
         cell_ff <= cell_in;
      end
   end

   assign cell_out = cell_ff;

endmodule

/* design/magnetometer_calibrate_heading.sv */
// Req to rsp: front stages, CORDIC cells, output register.
// One sample per cycle unless halted; one CORDIC cell per step.
// The whole pipe halts while a result is held by rsp_stall.
// Reset (synchronous, active high) empties the pipe and loads identity
// gains, zero bias, identity soft-iron matrix and zero declination.
module magnetometer_calibrate_heading import mch_pkg::*; #(
   parameter int CORDIC_STEPS = CordicStepsDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_raw_x,
   input  logic signed [15:0] req_raw_y,
   input  logic signed [15:0] req_raw_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [23:0] rsp_calibrated_x,
   output logic signed [23:0] rsp_calibrated_y,
   output logic signed [23:0] rsp_calibrated_z,
   output logic [8:0]         rsp_heading_deg,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [63:0]        csr_wdata
);

   localparam int NCell = (CORDIC_STEPS < TableLen) ? CORDIC_STEPS : TableLen;

   logic [47:0]       axis_scale_ff, iron_row_x_ff, iron_row_y_ff, iron_row_z_ff;
   logic [59:0]       axis_bias_ff;
   logic signed [8:0] decl_ff;

   logic              advance;
   cell_type          chain [NCell+1];
   logic              out_vld_ff;
   logic signed [23:0] cx_ff, cy_ff, cz_ff;
   logic [8:0]        head_ff;
   logic [8:0]        head_in;

   // registers
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         axis_scale_ff <= 48'h800080008000;
         axis_bias_ff  <= '0;
         iron_row_x_ff <= 48'h4000;
         iron_row_y_ff <= 48'h40000000;
         iron_row_z_ff <= 48'h400000000000;
         decl_ff       <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_AXIS_SCALE: axis_scale_ff <= csr_wdata[47:0];
            CSR_AXIS_BIAS:  axis_bias_ff  <= csr_wdata[59:0];
            CSR_IRON_ROW_X: iron_row_x_ff <= csr_wdata[47:0];
            CSR_IRON_ROW_Y: iron_row_y_ff <= csr_wdata[47:0];
            CSR_IRON_ROW_Z: iron_row_z_ff <= csr_wdata[47:0];
            CSR_DECL:       decl_ff       <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   // pipe moves unless a held result blocks it
   assign advance   = !(out_vld_ff && rsp_stall);
   assign req_stall = !advance;

   mch_front u_front (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_vld     (req_valid),
      .raw_x      (req_raw_x),
      .raw_y      (req_raw_y),
      .raw_z      (req_raw_z),
      .axis_scale (axis_scale_ff),
      .axis_bias  (axis_bias_ff),
      .iron_row_x (iron_row_x_ff),
      .iron_row_y (iron_row_y_ff),
      .iron_row_z (iron_row_z_ff),
      .cell_out   (chain[0])
   );

   for (genvar i = 0; i < NCell; i++) begin : g_cell
      mch_cordic_cell #(.STEP(i)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .cell_in  (chain[i]),
         .cell_out (chain[i+1])
      );
   end

   // round, sign, declination, wrap
   always_comb begin
      cell_type               c;
      logic [AngW-1:0]        mag;
      logic signed [10:0]     h;
      logic signed [10:0]     d;
      c   = chain[NCell];
      mag = c.ang[AngW-1] ? AngW'(-c.ang) : AngW'(c.ang);
      mag = (mag + AngW'(32768)) >> 16;
      h   = c.ang[AngW-1] ? -11'(mag) : 11'(mag);
      if (c.zero) h = '0;
      if (c.neg)  h = -h;
      d = 11'(decl_ff);
      if (d > 11'sd180)  d = 11'sd180;
      if (d < -11'sd180) d = -11'sd180;
      h = h + d;
      if (h < 0)             h = h + 11'sd360;
      else if (h > 11'sd360) h = h - 11'sd360;
      head_in = h[8:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= chain[NCell].vld;
         cx_ff      <= chain[NCell].cx;
         cy_ff      <= chain[NCell].cy;
         cz_ff      <= chain[NCell].cz;
         head_ff    <= head_in;
      end
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_calibrated_x = cx_ff;
   assign rsp_calibrated_y = cy_ff;
   assign rsp_calibrated_z = cz_ff;
   assign rsp_heading_deg  = head_ff;

endmodule
